/* hdl/j2sc_pkg.sv */
// ----------------------------------------------------------------------------
// j2sc_pkg
// constants and helpers shared by the seconds-to-calendar pipeline
// ----------------------------------------------------------------------------
package j2sc_pkg;

  localparam int EPOCH_W    = 31;
  localparam int TOTAL_W    = 32;
  localparam int YEAR_W     = 7;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;

  localparam int HALF_DAY_SECS = 43200;

  // 86400 = 2^7 * 675: the low bits pass straight into the second of day
  localparam int DAY_LO_BITS = 7;
  localparam int DAY_DIV     = 675;
  localparam int DAYS_W      = 15;
  localparam int DAY_REM_W   = 10;
  localparam int SOD_W       = DAY_REM_W + DAY_LO_BITS;

  localparam int QUAD_DAYS   = 1461;
  localparam int QUAD_W      = 5;
  localparam int QREM_W      = 11;

  localparam int HOUR_SECS   = 3600;
  localparam int HREM_W      = 12;
  localparam int MIN_SECS    = 60;

  localparam int DOY_W       = 9;
  localparam int YQ_W        = 2;

  // first day of each year within a four-year group, the leap year first
  localparam int YEAR1_START = 366;
  localparam int YEAR2_START = 731;
  localparam int YEAR3_START = 1096;

  // day of year on which a month starts, month index from 0
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mon_idx,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    case (mon_idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon_idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

/* hdl/j2sc_cdiv.sv */
// ----------------------------------------------------------------------------
// j2sc_cdiv
// three-stage elastic divider by a constant: reciprocal multiply, remainder,
// one-step correction; a sideband rides along with each item
// ----------------------------------------------------------------------------
module j2sc_cdiv #(
  parameter int W   = 25,
  parameter int DIV = 675,
  parameter int QW  = 15,
  parameter int RW  = 10,
  parameter int SW  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  in_x,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_q,
  output logic [RW-1:0] out_r,
  output logic [SW-1:0] out_side
);

  localparam longint unsigned M = (64'd1 << W) / DIV;
  localparam int MW  = $clog2(M + 1);
  localparam int PW  = W + MW;
  localparam int RPW = $clog2(2 * DIV);
  localparam logic [MW-1:0]  M_C     = MW'(M);
  localparam logic [W-1:0]   DIV_W   = W'(DIV);
  localparam logic [RPW-1:0] DIV_R   = RPW'(DIV);

  logic           v1_r, v2_r, v3_r;
  logic           rdy1, rdy2, rdy3;
  logic [W-1:0]   x1_r;
  logic [PW-1:0]  p1_r;
  logic [SW-1:0]  side1_r, side2_r, side3_r;
  logic [MW-1:0]  q2_r, q3_r;
  logic [RPW-1:0] r2_r, r3_r;
  logic [MW-1:0]  qe;
  logic [W-1:0]   diff;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign qe   = MW'(p1_r >> W);
  assign diff = x1_r - W'(qe) * DIV_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r    <= in_x;
      p1_r    <= PW'(in_x) * PW'(M_C);
      side1_r <= in_side;
    end
    if (rdy2) begin
      q2_r    <= qe;
      r2_r    <= RPW'(diff);
      side2_r <= side1_r;
    end
    if (rdy3) begin
      if (r2_r >= DIV_R) begin
        q3_r <= q2_r + MW'(1);
        r3_r <= r2_r - DIV_R;
      end else begin
        q3_r <= q2_r;
        r3_r <= r2_r;
      end
      side3_r <= side2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_q     = QW'(q3_r);
  assign out_r     = RW'(r3_r);
  assign out_side  = side3_r;

  a_rem_pre: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (r2_r < DIV_R) || ((r2_r - DIV_R) < DIV_R))
    else $error("quotient estimate off by more than one");

  a_rem_post: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> r3_r < DIV_R)
    else $error("corrected remainder out of range");

endmodule

/* hdl/j2sc_cal.sv */
// ----------------------------------------------------------------------------
// j2sc_cal
// splits the day within a four-year group into year, month and day; the
// second stage is the output register
// ----------------------------------------------------------------------------
module j2sc_cal (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [j2sc_pkg::QUAD_W-1:0]    in_quad,
  input  logic [j2sc_pkg::QREM_W-1:0]    in_qrem,
  input  logic [j2sc_pkg::HOUR_W-1:0]    in_hour,
  input  logic [j2sc_pkg::MIN_W-1:0]     in_min,
  input  logic [j2sc_pkg::SEC_W-1:0]     in_sec,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [j2sc_pkg::YEAR_W-1:0]    out_year,
  output logic [j2sc_pkg::MONTH_W-1:0]   out_month,
  output logic [j2sc_pkg::DAY_W-1:0]     out_day,
  output logic [j2sc_pkg::HOUR_W-1:0]    out_hour,
  output logic [j2sc_pkg::MIN_W-1:0]     out_min,
  output logic [j2sc_pkg::SEC_W-1:0]     out_sec
);

  logic                          va_r, vb_r;
  logic                          rdya, rdyb;
  logic [j2sc_pkg::YQ_W-1:0]     yq_nxt;
  logic [j2sc_pkg::QREM_W-1:0]   base;
  logic [j2sc_pkg::YEAR_W-1:0]   year_a_r;
  logic [j2sc_pkg::DOY_W-1:0]    doy_a_r;
  logic                          leap_a_r;
  logic [j2sc_pkg::HOUR_W-1:0]   hour_a_r;
  logic [j2sc_pkg::MIN_W-1:0]    min_a_r;
  logic [j2sc_pkg::SEC_W-1:0]    sec_a_r;
  logic [j2sc_pkg::MONTH_W-1:0]  mon_idx;
  logic [j2sc_pkg::DOY_W-1:0]    day_full;
  logic [j2sc_pkg::YEAR_W-1:0]   year_r;
  logic [j2sc_pkg::MONTH_W-1:0]  month_r;
  logic [j2sc_pkg::DAY_W-1:0]    day_r;
  logic [j2sc_pkg::HOUR_W-1:0]   hour_r;
  logic [j2sc_pkg::MIN_W-1:0]    min_r;
  logic [j2sc_pkg::SEC_W-1:0]    sec_r;

  assign rdyb     = !vb_r || out_ready;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  // year within the group
  always_comb begin
    if (in_qrem < j2sc_pkg::QREM_W'(j2sc_pkg::YEAR1_START)) begin
      yq_nxt = 2'd0;
      base   = '0;
    end else if (in_qrem < j2sc_pkg::QREM_W'(j2sc_pkg::YEAR2_START)) begin
      yq_nxt = 2'd1;
      base   = j2sc_pkg::QREM_W'(j2sc_pkg::YEAR1_START);
    end else if (in_qrem < j2sc_pkg::QREM_W'(j2sc_pkg::YEAR3_START)) begin
      yq_nxt = 2'd2;
      base   = j2sc_pkg::QREM_W'(j2sc_pkg::YEAR2_START);
    end else begin
      yq_nxt = 2'd3;
      base   = j2sc_pkg::QREM_W'(j2sc_pkg::YEAR3_START);
    end
  end

  // month search over the start table
  always_comb begin
    mon_idx = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy_a_r >= j2sc_pkg::month_start(j2sc_pkg::MONTH_W'(i), leap_a_r)) begin
        mon_idx = j2sc_pkg::MONTH_W'(i);
      end
    end
    day_full = doy_a_r - j2sc_pkg::month_start(mon_idx, leap_a_r) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdya) begin
      year_a_r <= {in_quad, yq_nxt};
      doy_a_r  <= j2sc_pkg::DOY_W'(in_qrem - base);
      leap_a_r <= (yq_nxt == 2'd0);
      hour_a_r <= in_hour;
      min_a_r  <= in_min;
      sec_a_r  <= in_sec;
    end
    if (rdyb) begin
      year_r  <= year_a_r;
      month_r <= mon_idx + j2sc_pkg::MONTH_W'(1);
      day_r   <= j2sc_pkg::DAY_W'(day_full);
      hour_r  <= hour_a_r;
      min_r   <= min_a_r;
      sec_r   <= sec_a_r;
    end
  end

  assign out_valid = vb_r;
  assign out_year  = year_r;
  assign out_month = month_r;
  assign out_day   = day_r;
  assign out_hour  = hour_r;
  assign out_min   = min_r;
  assign out_sec   = sec_r;

  a_doy: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> (doy_a_r < 9'd365) || (leap_a_r && (doy_a_r == 9'd365)))
    else $error("day of year out of range");

  a_date: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (month_r >= 4'd1) && (month_r <= 4'd12) && (day_r >= 5'd1))
    else $error("month or day out of range");

endmodule

/* hdl/j2000_seconds_to_calendar_core.sv */
// ----------------------------------------------------------------------------
// j2000_seconds_to_calendar_core
// seconds since 2000-01-01 12:00:00 to calendar date and time of day
// ----------------------------------------------------------------------------
// pipeline: an input register, four three-stage constant dividers and two
//   calendar stages
// throughput: one item per cycle while out_ready is high; every stage has its own
//   valid and stalls only when the stage ahead of it is full
// reset: synchronous active-low rst_n clears all valid bits; payload is kept
// ----------------------------------------------------------------------------
module j2000_seconds_to_calendar_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [j2sc_pkg::EPOCH_W-1:0]     in_epoch_seconds,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [j2sc_pkg::YEAR_W-1:0]      out_year_offset,
  output logic [j2sc_pkg::MONTH_W-1:0]     out_month_number,
  output logic [j2sc_pkg::DAY_W-1:0]       out_day_of_month,
  output logic [j2sc_pkg::HOUR_W-1:0]      out_hour_of_day,
  output logic [j2sc_pkg::MIN_W-1:0]       out_minute_of_hour,
  output logic [j2sc_pkg::SEC_W-1:0]       out_second_of_minute
);

  localparam int DAYX_W = j2sc_pkg::TOTAL_W - j2sc_pkg::DAY_LO_BITS;
  localparam int HSIDE_W = j2sc_pkg::QUAD_W + j2sc_pkg::QREM_W;
  localparam int MSIDE_W = HSIDE_W + j2sc_pkg::HOUR_W;

  logic                             v0_r, rdy0;
  logic [j2sc_pkg::TOTAL_W-1:0]     total_r;

  logic                             day_v, day_rdy, day_in_rdy;
  logic [j2sc_pkg::DAYS_W-1:0]      day_q;
  logic [j2sc_pkg::DAY_REM_W-1:0]   day_rem;
  logic [j2sc_pkg::DAY_LO_BITS-1:0] day_lo;

  logic                             qd_v, qd_rdy;
  logic [j2sc_pkg::QUAD_W-1:0]      qd_q;
  logic [j2sc_pkg::QREM_W-1:0]      qd_rem;
  logic [j2sc_pkg::SOD_W-1:0]       qd_sod;

  logic                             hr_v, hr_rdy;
  logic [j2sc_pkg::HOUR_W-1:0]      hr_q;
  logic [j2sc_pkg::HREM_W-1:0]      hr_rem;
  logic [HSIDE_W-1:0]               hr_side;

  logic                             mn_v, mn_rdy;
  logic [j2sc_pkg::MIN_W-1:0]       mn_q;
  logic [j2sc_pkg::SEC_W-1:0]       mn_rem;
  logic [MSIDE_W-1:0]               mn_side;

  assign rdy0     = !v0_r || day_in_rdy;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      total_r <= j2sc_pkg::TOTAL_W'(in_epoch_seconds)
               + j2sc_pkg::TOTAL_W'(j2sc_pkg::HALF_DAY_SECS);
    end
  end

  // day count and second of day
  j2sc_cdiv #(
    .W(DAYX_W), .DIV(j2sc_pkg::DAY_DIV), .QW(j2sc_pkg::DAYS_W),
    .RW(j2sc_pkg::DAY_REM_W), .SW(j2sc_pkg::DAY_LO_BITS)
  ) u_day (
    .clk(clk), .rst_n(rst_n),
    .in_valid(v0_r), .in_ready(day_in_rdy),
    .in_x(total_r[j2sc_pkg::TOTAL_W-1:j2sc_pkg::DAY_LO_BITS]),
    .in_side(total_r[j2sc_pkg::DAY_LO_BITS-1:0]),
    .out_valid(day_v), .out_ready(day_rdy),
    .out_q(day_q), .out_r(day_rem), .out_side(day_lo)
  );

  // four-year groups since 2000
  j2sc_cdiv #(
    .W(j2sc_pkg::DAYS_W), .DIV(j2sc_pkg::QUAD_DAYS), .QW(j2sc_pkg::QUAD_W),
    .RW(j2sc_pkg::QREM_W), .SW(j2sc_pkg::SOD_W)
  ) u_quad (
    .clk(clk), .rst_n(rst_n),
    .in_valid(day_v), .in_ready(day_rdy),
    .in_x(day_q), .in_side({day_rem, day_lo}),
    .out_valid(qd_v), .out_ready(qd_rdy),
    .out_q(qd_q), .out_r(qd_rem), .out_side(qd_sod)
  );

  j2sc_cdiv #(
    .W(j2sc_pkg::SOD_W), .DIV(j2sc_pkg::HOUR_SECS), .QW(j2sc_pkg::HOUR_W),
    .RW(j2sc_pkg::HREM_W), .SW(HSIDE_W)
  ) u_hour (
    .clk(clk), .rst_n(rst_n),
    .in_valid(qd_v), .in_ready(qd_rdy),
    .in_x(qd_sod), .in_side({qd_q, qd_rem}),
    .out_valid(hr_v), .out_ready(hr_rdy),
    .out_q(hr_q), .out_r(hr_rem), .out_side(hr_side)
  );

  j2sc_cdiv #(
    .W(j2sc_pkg::HREM_W), .DIV(j2sc_pkg::MIN_SECS), .QW(j2sc_pkg::MIN_W),
    .RW(j2sc_pkg::SEC_W), .SW(MSIDE_W)
  ) u_min (
    .clk(clk), .rst_n(rst_n),
    .in_valid(hr_v), .in_ready(hr_rdy),
    .in_x(hr_rem), .in_side({hr_side, hr_q}),
    .out_valid(mn_v), .out_ready(mn_rdy),
    .out_q(mn_q), .out_r(mn_rem), .out_side(mn_side)
  );

  j2sc_cal u_cal (
    .clk(clk), .rst_n(rst_n),
    .in_valid(mn_v), .in_ready(mn_rdy),
    .in_quad(mn_side[MSIDE_W-1:MSIDE_W-j2sc_pkg::QUAD_W]),
    .in_qrem(mn_side[j2sc_pkg::QREM_W+j2sc_pkg::HOUR_W-1:j2sc_pkg::HOUR_W]),
    .in_hour(mn_side[j2sc_pkg::HOUR_W-1:0]),
    .in_min(mn_q), .in_sec(mn_rem),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_year(out_year_offset), .out_month(out_month_number),
    .out_day(out_day_of_month), .out_hour(out_hour_of_day),
    .out_min(out_minute_of_hour), .out_sec(out_second_of_minute)
  );

endmodule
